@@ rtl/bdt_pkg.sv @@
// ============================================================================
// bdt_pkg: shared definitions for the bonded device table
// Types, operation and state codes, field widths and the command and status
// groups that pass between the controller and the datapath.
// ============================================================================
package bdt_pkg;

  localparam int unsigned BDT_ENTRIES = 16;

  localparam int unsigned OP_W      = 2;
  localparam int unsigned SLOT_W    = 4;
  localparam int unsigned TYPE_W    = 8;
  localparam int unsigned ADDR_W    = 48;
  localparam int unsigned SEQ_W     = 32;
  localparam int unsigned CNT_OUT_W = 5;

  localparam int unsigned IN_TUSER_W  = OP_W;
  localparam int unsigned IN_TDATA_W  = 64;
  localparam int unsigned OUT_TDATA_W = 72;

  // Output beat layout, lowest bit first.
  localparam int unsigned OUT_STATUS_LSB = 0;
  localparam int unsigned OUT_SLOT_LSB   = 1;
  localparam int unsigned OUT_TYPE_LSB   = OUT_SLOT_LSB + SLOT_W;
  localparam int unsigned OUT_ADDR_LSB   = OUT_TYPE_LSB + TYPE_W;
  localparam int unsigned OUT_CNT_LSB    = OUT_ADDR_LSB + ADDR_W;
  localparam int unsigned OUT_USED_W     = OUT_CNT_LSB + CNT_OUT_W;

  // Input beat layout, lowest bit first.
  localparam int unsigned IN_SLOT_LSB = 0;
  localparam int unsigned IN_TYPE_LSB = IN_SLOT_LSB + SLOT_W;
  localparam int unsigned IN_ADDR_LSB = IN_TYPE_LSB + TYPE_W;

  typedef enum logic [OP_W-1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_READ   = 2'd2,
    OP_COUNT  = 2'd3
  } bdt_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_RDSLOT,
    ST_DONE
  } bdt_state_t;

  typedef struct packed {
    logic [TYPE_W-1:0] peer_type;
    logic [ADDR_W-1:0] peer_addr;
    logic [SEQ_W-1:0]  seq;
  } bdt_entry_t;

  // Controller to datapath.
  typedef struct packed {
    logic cap;      // latch the accepted beat and clear the scan state
    logic scan_rd;  // read the slot under the scan counter, then advance it
    logic slot_rd;  // read the slot named by the request
    logic commit;   // apply the operation and load the result register
  } bdt_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    bdt_op_t in_op;     // opcode of the beat on the input port
    logic    scan_last; // scan counter is at the last slot
    logic    out_busy;  // result register holds a beat not yet taken
  } bdt_sts_t;

endpackage

@@ rtl/bonded_device_table_unit.sv @@
// An add scans the slot memory one slot per cycle through its registered
// read port before it commits; a read fetches the named slot first, and a
// remove or count goes straight to the commit. One request is in flight at
// a time; a finished result waits in the output register while the next
// request is taken.
// Reset (synchronous, active low) empties every slot and clears the count.
// ============================================================================
// bonded_device_table_unit: table of bonded peer devices
// A fixed set of slots, each holding an address type, a 48-bit address and
// a store sequence number. Add reuses the slot that already holds the same
// device, else the highest-numbered empty slot, else the least recently
// stored slot. Remove, read and count act on the valid marks and the count.
// ============================================================================
module bonded_device_table_unit #(
  parameter int unsigned ENTRIES = bdt_pkg::BDT_ENTRIES
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Request channel.
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // in_tdata, low bit up: slot[3:0], peer_type[11:4], peer_addr[59:12],
  // zero fill [63:60].
  input  logic [bdt_pkg::IN_TDATA_W-1:0]  in_tdata,
  // in_tuser: opcode[1:0] (add, remove, read slot, read count).
  input  logic [bdt_pkg::IN_TUSER_W-1:0]  in_tuser,
  // Result channel.
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // out_tdata, low bit up: status[0], result_slot[4:1], result_type[12:5],
  // result_addr[60:13], entry_count[65:61], zero fill [71:66].
  output logic [bdt_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import bdt_pkg::*;

  bdt_cmd_t cmd;
  bdt_sts_t sts;

  // The controller only sequences; every stored value lives in the datapath.
  bdt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath scans one slot per cycle during an add and keeps the
  // result in its output register until the downstream side takes the beat.
  bdt_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule

@@ rtl/bdt_ctrl.sv @@
// ============================================================================
// bdt_ctrl: operation sequencer
// Accepts one request at a time, steps the slot scan or the slot read, and
// commits the operation once the result register is free.
// ============================================================================
module bdt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  bdt_pkg::bdt_sts_t sts,
  output bdt_pkg::bdt_cmd_t cmd
);
  import bdt_pkg::*;

  bdt_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.cap = 1'b1;
          unique case (sts.in_op)
            OP_ADD:  state_nxt = ST_SCAN;
            OP_READ: state_nxt = ST_RDSLOT;
            default: state_nxt = ST_DONE;
          endcase
        end
      end
      ST_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (sts.scan_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // The last slot read is compared in this cycle.
        state_nxt = ST_DONE;
      end
      ST_RDSLOT: begin
        cmd.slot_rd = 1'b1;
        state_nxt   = ST_DONE;
      end
      ST_DONE: begin
        if (!sts.out_busy) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/bdt_dp.sv @@
// ============================================================================
// bdt_dp: slot storage, scan logic and result register
// Holds the slot memory and valid bits, evaluates one slot per cycle during
// an add, and applies each operation when the controller commits it.
// ============================================================================
module bdt_dp #(
  parameter int unsigned ENTRIES = bdt_pkg::BDT_ENTRIES
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [bdt_pkg::IN_TDATA_W-1:0]      in_tdata,
  input  logic [bdt_pkg::IN_TUSER_W-1:0]      in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [bdt_pkg::OUT_TDATA_W-1:0]     out_tdata,
  input  bdt_pkg::bdt_cmd_t                   cmd,
  output bdt_pkg::bdt_sts_t                   sts
);
  import bdt_pkg::*;

  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW = $clog2(ENTRIES + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

  // Storage.
  bdt_entry_t mem [ENTRIES];
  bdt_entry_t rd_data_r;
  logic [ENTRIES-1:0] valid_r, valid_nxt;
  logic [CW-1:0]      count_r, count_nxt;

  // Latched request.
  bdt_op_t           op_r;
  logic [SLOT_W-1:0] slot_r;
  logic [TYPE_W-1:0] type_r;
  logic [ADDR_W-1:0] addr_r;

  // Scan state.
  logic [IW-1:0]    scan_cnt_r, scan_cnt_nxt;
  logic             proc_r;
  logic [IW-1:0]    proc_idx_r;
  logic             have_match_r, have_match_nxt;
  logic             have_empty_r, have_empty_nxt;
  logic             have_low_r, have_low_nxt;
  logic [IW-1:0]    match_at_r, match_at_nxt;
  logic [IW-1:0]    empty_at_r, empty_at_nxt;
  logic [IW-1:0]    low_at_r, low_at_nxt;
  logic [SEQ_W-1:0] highest_r, highest_nxt;
  logic [SEQ_W-1:0] lowest_r, lowest_nxt;

  // Commit.
  logic [IW-1:0]    slot_idx;
  logic             slot_present;
  logic [IW-1:0]    use_idx;
  logic             mem_we;
  bdt_entry_t       wr_entry;
  logic [IW-1:0]    rd_addr;

  // Result register.
  logic              out_vld_r, out_vld_nxt;
  logic              o_status_r;
  logic [SLOT_W-1:0] o_slot_r;
  logic [TYPE_W-1:0] o_type_r;
  logic [ADDR_W-1:0] o_addr_r;
  logic [CNT_OUT_W-1:0] o_count_r;
  logic              o_status_nxt;
  logic [SLOT_W-1:0] o_slot_nxt;
  logic [TYPE_W-1:0] o_type_nxt;
  logic [ADDR_W-1:0] o_addr_nxt;

  assign sts.in_op     = bdt_op_t'(in_tuser);
  assign sts.scan_last = (scan_cnt_r == LAST_IDX);
  assign sts.out_busy  = out_vld_r && !out_tready;

  assign slot_idx     = IW'(slot_r);
  assign slot_present = ({{(32-SLOT_W){1'b0}}, slot_r} < 32'(ENTRIES)) && valid_r[slot_idx];
  assign rd_addr      = cmd.slot_rd ? slot_idx : scan_cnt_r;

  // Request latch.
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      op_r   <= bdt_op_t'(in_tuser);
      slot_r <= in_tdata[IN_SLOT_LSB +: SLOT_W];
      type_r <= in_tdata[IN_TYPE_LSB +: TYPE_W];
      addr_r <= in_tdata[IN_ADDR_LSB +: ADDR_W];
    end
  end

  // Slot memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[use_idx] <= wr_entry;
    end
    if (cmd.scan_rd || cmd.slot_rd) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Per-slot evaluation of the entry that arrived from the memory.
  always_comb begin
    scan_cnt_nxt   = scan_cnt_r;
    have_match_nxt = have_match_r;
    have_empty_nxt = have_empty_r;
    have_low_nxt   = have_low_r;
    match_at_nxt   = match_at_r;
    empty_at_nxt   = empty_at_r;
    low_at_nxt     = low_at_r;
    highest_nxt    = highest_r;
    lowest_nxt     = lowest_r;
    if (cmd.cap) begin
      scan_cnt_nxt   = '0;
      have_match_nxt = 1'b0;
      have_empty_nxt = 1'b0;
      have_low_nxt   = 1'b0;
      highest_nxt    = '0;
      lowest_nxt     = '1;
    end else begin
      if (cmd.scan_rd && !sts.scan_last) begin
        scan_cnt_nxt = scan_cnt_r + 1'b1;
      end
      if (proc_r) begin
        if (valid_r[proc_idx_r]) begin
          // The last matching slot wins; the first lowest sequence wins.
          if (rd_data_r.peer_addr == addr_r && rd_data_r.peer_type == type_r) begin
            have_match_nxt = 1'b1;
            match_at_nxt   = proc_idx_r;
          end
          if (rd_data_r.seq > highest_r) begin
            highest_nxt = rd_data_r.seq;
          end
          if (!have_low_r || rd_data_r.seq < lowest_r) begin
            have_low_nxt = 1'b1;
            low_at_nxt   = proc_idx_r;
            lowest_nxt   = rd_data_r.seq;
          end
        end else begin
          have_empty_nxt = 1'b1;
          empty_at_nxt   = proc_idx_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_cnt_r   <= '0;
      proc_r       <= 1'b0;
      have_match_r <= 1'b0;
      have_empty_r <= 1'b0;
      have_low_r   <= 1'b0;
    end else begin
      scan_cnt_r   <= scan_cnt_nxt;
      proc_r       <= cmd.scan_rd;
      have_match_r <= have_match_nxt;
      have_empty_r <= have_empty_nxt;
      have_low_r   <= have_low_nxt;
    end
  end

  always_ff @(posedge clk) begin
    proc_idx_r <= scan_cnt_r;
    match_at_r <= match_at_nxt;
    empty_at_r <= empty_at_nxt;
    low_at_r   <= low_at_nxt;
    highest_r  <= highest_nxt;
    lowest_r   <= lowest_nxt;
  end

  // Operation commit.
  always_comb begin
    priority if (have_match_r) begin
      use_idx = match_at_r;
    end else if (have_empty_r) begin
      use_idx = empty_at_r;
    end else begin
      use_idx = low_at_r;
    end
    wr_entry.peer_type = type_r;
    wr_entry.peer_addr = addr_r;
    wr_entry.seq       = highest_r + 1'b1;

    mem_we       = 1'b0;
    valid_nxt    = valid_r;
    count_nxt    = count_r;
    o_status_nxt = 1'b0;
    o_slot_nxt   = slot_r;
    o_type_nxt   = '0;
    o_addr_nxt   = '0;
    if (cmd.commit) begin
      unique case (op_r)
        OP_ADD: begin
          mem_we             = 1'b1;
          valid_nxt[use_idx] = 1'b1;
          o_slot_nxt         = SLOT_W'(use_idx);
          if (!have_match_r && have_empty_r) begin
            count_nxt = count_r + 1'b1;
          end
        end
        OP_REMOVE: begin
          if (slot_present) begin
            valid_nxt[slot_idx] = 1'b0;
            count_nxt           = count_r - 1'b1;
          end else begin
            o_status_nxt = 1'b1;
          end
        end
        OP_READ: begin
          if (slot_present) begin
            o_type_nxt = rd_data_r.peer_type;
            o_addr_nxt = rd_data_r.peer_addr;
          end else begin
            o_status_nxt = 1'b1;
          end
        end
        OP_COUNT: begin
        end
        default: begin
        end
      endcase
    end
    out_vld_nxt = cmd.commit ? 1'b1 : (out_tready ? 1'b0 : out_vld_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= '0;
      count_r   <= '0;
      out_vld_r <= 1'b0;
    end else begin
      valid_r   <= valid_nxt;
      count_r   <= count_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      o_status_r <= o_status_nxt;
      o_slot_r   <= o_slot_nxt;
      o_type_r   <= o_type_nxt;
      o_addr_r   <= o_addr_nxt;
      o_count_r  <= CNT_OUT_W'(count_nxt);
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{(OUT_TDATA_W-OUT_USED_W){1'b0}},
                       o_count_r, o_addr_r, o_type_r, o_slot_r, o_status_r};

endmodule

@@ rtl/bdt_checker.sv @@
// ============================================================================
// bdt_checker: port-level checks for the bonded device table
// Watches the top level's channels and flags handshake and sequencing
// errors.
// ============================================================================
module bdt_checker #(
  parameter int unsigned ENTRIES = bdt_pkg::BDT_ENTRIES
) (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [bdt_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import bdt_pkg::*;

  logic [CNT_OUT_W-1:0] count;
  assign count = out_tdata[OUT_CNT_LSB +: CNT_OUT_W];

  // A stalled result beat stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result beat withdrawn while stalled");

  // A stalled result beat keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result payload changed while stalled");

  // Only one request is in flight: the beat after an accept is not taken.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second request taken while one is in progress");

  // Reset leaves no result pending and the block ready for a request.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("block not idle after reset");

  // The reported count never exceeds the table size.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (ENTRIES > 31) || ({27'd0, count} <= 32'(ENTRIES)))
    else $error("entry count exceeds table size");

endmodule

bind bonded_device_table_unit bdt_checker #(
  .ENTRIES (ENTRIES)
) u_bdt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
